@@ design/sepr_pkg.sv @@
package sepr_pkg;

   // default sizing of the store
   localparam int STORE_DEPTH_DEF   = 256;
   localparam int ELEMENT_WIDTH_DEF = 32;

   // fixed field widths of the ports
   localparam int VALUE_W = 32;
   localparam int DEPTH_W = 9;
   localparam int INDEX_W = 8;
   localparam int CAP_W   = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // request operations
   typedef enum logic [2:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_PEEK     = 3'd2,
      OP_PICK     = 3'd3,
      OP_ROLL     = 3'd4,
      OP_BACKROLL = 3'd5,
      OP_DEPTH    = 3'd6,
      OP_RESET    = 3'd7
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_SHALLOW   = 2'd3
   } status_type;

endpackage

@@ design/sepr_ram.sv @@
module sepr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/stack_engine_pick_roll.sv @@
// stack engine with pick and roll, one request at a time
// steps from request beat to result beat: push, depth, reset and any request that
// fails or moves nothing go idle, finish; a good pop, peek or pick goes idle, read,
// finish; a roll or backroll that moves: idle, roll head, roll move, roll last,
// finish, held by rsp stalls; the single ram port pair moves one element per cycle
// reset (synchronous, active high) empties the stack and sets capacity to 256;
// no clearing pass, the element ram is only ever read below the count
module stack_engine_pick_roll #(
   parameter int STORE_DEPTH   = sepr_pkg::STORE_DEPTH_DEF,
   parameter int ELEMENT_WIDTH = sepr_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sepr_pkg::op_type               req_operation,
   input  logic [sepr_pkg::VALUE_W-1:0]   req_push_value,
   input  logic [sepr_pkg::INDEX_W-1:0]   req_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sepr_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [sepr_pkg::DEPTH_W-1:0]   rsp_depth,
   output sepr_pkg::status_type           rsp_status,
   input  logic                           csr_write_enable,
   input  logic [sepr_pkg::CAP_W-1:0]     csr_write_data
);

   import sepr_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(STORE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_ROLL_HEAD,
      S_ROLL_MOVE,
      S_ROLL_LAST,
      S_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CAP_W-1:0]         cap_ff, cap_in;
   logic [ADDR_W-1:0]        ptr_ff, ptr_in;
   logic [ADDR_W-1:0]        lim_ff, lim_in;
   logic                     dir_ff, dir_in;
   logic [ELEMENT_WIDTH-1:0] tmp_ff, tmp_in;
   logic [VALUE_W-1:0]       res_value_ff, res_value_in;
   status_type               res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]       rsp_read_value_ff, rsp_read_value_in;
   logic [DEPTH_W-1:0]       rsp_depth_ff, rsp_depth_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr;
   logic [ELEMENT_WIDTH-1:0] ram_wdata;
   logic                     ram_re;
   logic [ADDR_W-1:0]        ram_raddr;
   logic [ELEMENT_WIDTH-1:0] ram_rdata;

   logic [CMP_W-1:0]  count_w, cap_w, idx_w;
   logic [ADDR_W-1:0] top_addr, pick_addr, step, ptr_nxt, ptr_nxt2;
   logic              push_ok, slot_free;

   sepr_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // widened operands for the bound checks
   assign count_w   = CMP_W'(count_ff);
   assign cap_w     = CMP_W'(cap_ff);
   assign idx_w     = CMP_W'(req_index);
   assign push_ok   = (count_w < cap_w) && (count_w < DEPTH_C);
   assign top_addr  = ADDR_W'(count_w - CMP_W'(1));
   assign pick_addr = ADDR_W'(count_w - CMP_W'(1) - idx_w);

   // shared address stepper, up for backroll and down for roll
   assign step     = dir_ff ? ADDR_W'(1) : '1;
   assign ptr_nxt  = ptr_ff + step;
   assign ptr_nxt2 = ptr_nxt + step;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      cap_in            = cap_ff;
      ptr_in            = ptr_ff;
      lim_in            = lim_ff;
      dir_in            = dir_ff;
      tmp_in            = tmp_ff;
      res_value_in      = res_value_ff;
      res_status_in     = res_status_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_depth_in      = rsp_depth_ff;
      rsp_status_in     = rsp_status_ff;
      ram_we            = 1'b0;
      ram_waddr         = ptr_ff;
      ram_wdata         = ram_rdata;
      ram_re            = 1'b0;
      ram_raddr         = ptr_nxt;

      // capacity register
      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_value_in  = '0;
               res_status_in = STAT_OK;
               state_in      = S_FINISH;
               unique case (req_operation)
                  OP_PUSH: begin
                     if (push_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(count_ff);
                        ram_wdata = ELEMENT_WIDTH'(req_push_value);
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        res_status_in = STAT_OVERFLOW;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_UNDERFLOW;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = top_addr;
                        count_in  = count_ff - CNT_W'(1);
                        state_in  = S_READ;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_UNDERFLOW;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = top_addr;
                        state_in  = S_READ;
                     end
                  end
                  OP_PICK: begin
                     if (idx_w >= count_w) begin
                        res_status_in = STAT_UNDERFLOW;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = pick_addr;
                        state_in  = S_READ;
                     end
                  end
                  OP_ROLL, OP_BACKROLL: begin
                     if (req_index == '0) begin
                        // nothing moves
                     end else if (idx_w >= count_w) begin
                        res_status_in = STAT_SHALLOW;
                     end else begin
                        ram_re = 1'b1;
                        if (req_operation == OP_ROLL) begin
                           // carry the top down to the base
                           ram_raddr = top_addr;
                           ptr_in    = top_addr;
                           lim_in    = pick_addr;
                           dir_in    = 1'b0;
                        end else begin
                           // carry the base up to the top
                           ram_raddr = pick_addr;
                           ptr_in    = pick_addr;
                           lim_in    = top_addr;
                           dir_in    = 1'b1;
                        end
                        state_in = S_ROLL_HEAD;
                     end
                  end
                  OP_DEPTH: begin
                     // count only
                  end
                  OP_RESET: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            res_value_in = VALUE_W'(ram_rdata);
            state_in     = S_FINISH;
         end
         S_ROLL_HEAD: begin
            // keep the moving element, fetch its neighbour
            tmp_in   = ram_rdata;
            ram_re   = 1'b1;
            state_in = S_ROLL_MOVE;
         end
         S_ROLL_MOVE: begin
            // shift one element per cycle towards the far end
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_nxt;
            if (ptr_nxt == lim_ff) begin
               state_in = S_ROLL_LAST;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_nxt2;
            end
         end
         S_ROLL_LAST: begin
            ram_we    = 1'b1;
            ram_waddr = lim_ff;
            ram_wdata = tmp_ff;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = res_value_ff;
               rsp_depth_in      = DEPTH_W'(count_ff);
               rsp_status_in     = res_status_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff          <= state_in;
         count_ff          <= count_in;
         cap_ff            <= cap_in;
         rsp_valid_ff      <= rsp_valid_in;
         ptr_ff            <= ptr_in;
         lim_ff            <= lim_in;
         dir_ff            <= dir_in;
         tmp_ff            <= tmp_in;
         res_value_ff      <= res_value_in;
         res_status_ff     <= res_status_in;
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_depth_ff      <= rsp_depth_in;
         rsp_status_ff     <= rsp_status_in;
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_depth      = rsp_depth_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

@@ design/sepr_chk.sv @@
module sepr_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input sepr_pkg::op_type             req_operation,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sepr_pkg::VALUE_W-1:0] rsp_read_value,
   input logic [sepr_pkg::DEPTH_W-1:0] rsp_depth,
   input sepr_pkg::status_type         rsp_status
);

   import sepr_pkg::*;

   op_type     op_q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] outst_ff;
   logic       req_beat, rsp_beat;
   op_type     head_op;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign head_op  = op_q_ff[rd_ptr_ff];

   // track operations of requests still owed a result
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         outst_ff  <= '0;
      end else begin
         if (req_beat) begin
            op_q_ff[wr_ptr_ff] <= req_operation;
            wr_ptr_ff          <= !wr_ptr_ff;
         end
         if (rsp_beat) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         outst_ff <= outst_ff + 2'(req_beat) - 2'(rsp_beat);
      end
   end

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_depth) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // no result without a request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 2'd0)
      else $error("result beat without a request");

   // overflow only answers a push
   a_overflow_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OVERFLOW |-> head_op == OP_PUSH)
      else $error("overflow on a non-push request");

   // too shallow only answers a roll or backroll
   a_shallow_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_SHALLOW |->
         head_op == OP_ROLL || head_op == OP_BACKROLL)
      else $error("too shallow on a non-roll request");

   // reset operation leaves an empty stack
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && head_op == OP_RESET |->
         rsp_depth == '0 && rsp_status == STAT_OK && rsp_read_value == '0)
      else $error("reset operation left a non-empty stack");

endmodule

bind stack_engine_pick_roll sepr_chk u_sepr_chk (.*);

@@ tb/tb_stack_engine_pick_roll.sv @@
module tb_stack_engine_pick_roll;
   timeunit 1ns;
   timeprecision 1ps;

   import sepr_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int LIMIT       = 3_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 300;

   // one answer as the block should return it
   typedef struct {
      logic [VALUE_W-1:0] read_value;
      logic [DEPTH_W-1:0] depth;
      status_type         status;
   } stack_answer_type;

   // mirror of the stack contents plus the answers still owed by the block
   class stack_mirror_type;
      logic [VALUE_W-1:0] cells [STORE_DEPTH_DEF];
      int unsigned        count;
      int unsigned        capacity;
      stack_answer_type   answers_due [$];
      int unsigned        errors;

      function new();
         count    = 0;
         capacity = 32'(CAP_RESET);
         errors   = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = 32'(value);
      endfunction

      function int unsigned pending();
         return answers_due.size();
      endfunction

      // apply one accepted request beat and queue the answer it owes
      function void apply_request(op_type op, logic [VALUE_W-1:0] value,
                                  logic [INDEX_W-1:0] idx);
         stack_answer_type   ans;
         int                 room;
         int                 base;
         int                 k;
         logic [VALUE_W-1:0] moved;
         ans.read_value = '0;
         ans.status     = STAT_OK;
         room = (capacity > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : capacity;
         case (op)
            OP_PUSH: begin
               if (count >= room) begin
                  ans.status = STAT_OVERFLOW;
               end else begin
                  cells[count] = value;
                  count++;
               end
            end
            OP_POP: begin
               if (count == 0) begin
                  ans.status = STAT_UNDERFLOW;
               end else begin
                  count--;
                  ans.read_value = cells[count];
               end
            end
            OP_PEEK: begin
               if (count == 0) ans.status = STAT_UNDERFLOW;
               else ans.read_value = cells[count-1];
            end
            OP_PICK: begin
               if (idx >= count) ans.status = STAT_UNDERFLOW;
               else ans.read_value = cells[count-1-idx];
            end
            OP_ROLL: begin
               // top sinks to position idx, the ones above it rise
               if (idx != 0) begin
                  if (idx >= count) begin
                     ans.status = STAT_SHALLOW;
                  end else begin
                     base  = count - 1 - idx;
                     moved = cells[count-1];
                     for (k = count - 1; k > base; k--) cells[k] = cells[k-1];
                     cells[base] = moved;
                  end
               end
            end
            OP_BACKROLL: begin
               // position idx comes up to the top, the ones above it sink
               if (idx != 0) begin
                  if (idx >= count) begin
                     ans.status = STAT_SHALLOW;
                  end else begin
                     base  = count - 1 - idx;
                     moved = cells[base];
                     for (k = base; k < count - 1; k++) cells[k] = cells[k+1];
                     cells[count-1] = moved;
                  end
               end
            end
            OP_DEPTH: begin
            end
            default: begin
               count = 0;
            end
         endcase
         ans.depth = DEPTH_W'(count);
         answers_due.push_back(ans);
      endfunction

      // compare one result beat with the oldest answer owed
      function void check_answer(logic [VALUE_W-1:0] read_value,
                                 logic [DEPTH_W-1:0] depth, status_type status);
         stack_answer_type ans;
         if (answers_due.size() == 0) begin
            $display("%0t: result beat with nothing owed: value %h depth %0d status %0d",
                     $time, read_value, depth, status);
            errors++;
            return;
         end
         ans = answers_due.pop_front();
         if (read_value !== ans.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, ans.read_value,
                     read_value);
            errors++;
         end
         if (depth !== ans.depth) begin
            $display("%0t: depth expected %0d actual %0d", $time, ans.depth, depth);
            errors++;
         end
         if (status !== ans.status) begin
            $display("%0t: status expected %0d actual %0d", $time, ans.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   op_type               req_operation    = OP_DEPTH;
   logic [VALUE_W-1:0]   req_push_value   = '0;
   logic [INDEX_W-1:0]   req_index        = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [VALUE_W-1:0]   rsp_read_value;
   logic [DEPTH_W-1:0]   rsp_depth;
   status_type           rsp_status;
   logic                 csr_write_enable = 1'b0;
   logic [CAP_W-1:0]     csr_write_data   = '0;

   stack_mirror_type mirror = new();
   bit          no_idle      = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned cycle_count  = 0;

   stack_engine_pick_roll DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_push_value   (req_push_value),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_depth        (rsp_depth),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // result beats go to the mirror
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_answer(rsp_read_value, rsp_depth, rsp_status);
   end

   // cycle budget for the whole run
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("stack_engine_pick_roll: mismatch");
      $finish;
   end

   // receiver: stretches of stall and no stall, plus the long hold on request
   initial begin
      int r;
      int n;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall    <= 1'b1;
            n            = HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 8);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_stall <= 1'b0;
               n = $urandom_range(1, 8);
            end else if (r < 93) begin
               rsp_stall <= 1'b1;
               n = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               n = $urandom_range(10, 40);
            end
         end
         repeat (n) @(posedge clock);
      end
   end

   function automatic int sender_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one request beat and wait until it is taken
   task automatic send_request(op_type op, logic [VALUE_W-1:0] value,
                               logic [INDEX_W-1:0] idx);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_push_value <= value;
      req_index      <= idx;
      do @(posedge clock); while (req_stall);
      mirror.apply_request(op, value, idx);
   endtask

   // stop offering and wait for every owed answer
   task automatic settle();
      req_valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      settle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror.set_capacity(value);
   endtask

   // mostly positions inside the stack and near the top, some anywhere
   function automatic logic [INDEX_W-1:0] pick_index();
      int r;
      int top;
      r   = $urandom_range(0, 99);
      top = (mirror.count > 256) ? 255 : int'(mirror.count) - 1;
      if (mirror.count > 0 && r < 60)
         return INDEX_W'($urandom_range(0, (top > 15) ? 15 : top));
      if (mirror.count > 0 && r < 80) return INDEX_W'($urandom_range(0, top));
      return INDEX_W'($urandom_range(0, 255));
   endfunction

   // random requests, pushes favoured while below the target depth
   task automatic run_random(int n, int target);
      int                 r;
      op_type             op;
      logic [VALUE_W-1:0] value;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < ((mirror.count < target) ? 60 : 15)) begin
            op = OP_PUSH;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 18)      op = OP_POP;
            else if (r < 33) op = OP_PEEK;
            else if (r < 53) op = OP_PICK;
            else if (r < 71) op = OP_ROLL;
            else if (r < 89) op = OP_BACKROLL;
            else if (r < 97) op = OP_DEPTH;
            else             op = OP_RESET;
         end
         r = $urandom_range(0, 9);
         if (r == 0)      value = '0;
         else if (r == 1) value = '1;
         else             value = $urandom;
         send_request(op, value, pick_index());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stack corners
      send_request(OP_POP,      $urandom, INDEX_W'($urandom));
      send_request(OP_PEEK,     $urandom, INDEX_W'($urandom));
      send_request(OP_PICK,     $urandom, 8'd0);
      send_request(OP_ROLL,     $urandom, 8'd0);
      send_request(OP_BACKROLL, $urandom, 8'd0);
      send_request(OP_ROLL,     $urandom, 8'd1);
      send_request(OP_BACKROLL, $urandom, 8'd255);
      send_request(OP_DEPTH,    $urandom, INDEX_W'($urandom));
      // four elements, extremes of the value
      send_request(OP_PUSH, 32'h0000_0000, INDEX_W'($urandom));
      send_request(OP_PUSH, 32'hFFFF_FFFF, INDEX_W'($urandom));
      send_request(OP_PUSH, 32'hA5A5_A5A5, INDEX_W'($urandom));
      send_request(OP_PUSH, 32'h5A5A_5A5A, INDEX_W'($urandom));
      send_request(OP_PEEK,     $urandom, INDEX_W'($urandom));
      send_request(OP_PICK,     $urandom, 8'd3);
      send_request(OP_PICK,     $urandom, 8'd4);
      send_request(OP_PICK,     $urandom, 8'd255);
      // rolls down to the bottom and back
      send_request(OP_ROLL,     $urandom, 8'd3);
      send_request(OP_PICK,     $urandom, 8'd3);
      send_request(OP_BACKROLL, $urandom, 8'd3);
      send_request(OP_ROLL,     $urandom, 8'd4);
      send_request(OP_BACKROLL, $urandom, 8'd1);
      send_request(OP_ROLL,     $urandom, 8'd0);
      send_request(OP_POP,      $urandom, INDEX_W'($urandom));
      send_request(OP_DEPTH,    $urandom, INDEX_W'($urandom));
      send_request(OP_RESET,    $urandom, INDEX_W'($urandom));
      send_request(OP_POP,      $urandom, INDEX_W'($urandom));

      run_random(80, 40);

      // no room at all, then room for one
      write_capacity(9'd0);
      run_random(20, 10);
      write_capacity(9'd1);
      run_random(30, 5);

      // full capacity, back to back with no idling
      write_capacity(9'd256);
      no_idle = 1'b1;
      run_random(40, 30);
      no_idle = 1'b0;

      // fill to the very top and work the deepest positions
      while (mirror.count < STORE_DEPTH_DEF)
         send_request(OP_PUSH, $urandom, INDEX_W'($urandom));
      send_request(OP_PICK,     $urandom, 8'd255);
      send_request(OP_ROLL,     $urandom, 8'd255);
      send_request(OP_PICK,     $urandom, 8'd255);
      send_request(OP_BACKROLL, $urandom, 8'd255);
      send_request(OP_PICK,     $urandom, 8'd0);
      send_request(OP_PUSH,     $urandom, INDEX_W'($urandom));
      run_random(20, 256);

      // capacity below the count held
      write_capacity(9'd3);
      run_random(40, 10);

      // receiver holds off while requests keep coming
      write_capacity(9'd255);
      no_idle      = 1'b1;
      hold_request = 1'b1;
      run_random(40, 20);
      no_idle = 1'b0;

      write_capacity(CAP_W'($urandom_range(2, 254)));
      run_random(60, int'($urandom_range(5, 60)));
      write_capacity(9'd5);
      run_random(40, 8);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending() == 0)
         $display("stack_engine_pick_roll: match");
      else
         $display("stack_engine_pick_roll: mismatch");
      $finish;
   end

endmodule

@@ stack_engine_pick_roll.f @@
design/sepr_pkg.sv
design/sepr_ram.sv
design/stack_engine_pick_roll.sv
design/sepr_chk.sv
tb/tb_stack_engine_pick_roll.sv
